>>> sv/lfo_pkg.sv
// Shared constants, codes and the quarter-wave sine table of the LFO level generator.
// No dependencies; used by the divider, the wave unit and the top level.
package lfo_pkg;

  localparam int PHASE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int UP_SHIFT   = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
  localparam int DOWN_SHIFT = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;

  localparam int SPAN_W  = 32;
  localparam int LEVEL_W = 24;
  localparam int CC_W    = 24;
  localparam int PO_W    = 16;
  localparam int OUT_W   = 14;
  localparam int CFG_W   = 32;
  localparam int NUM_W   = CC_W + SPAN_W + UP_SHIFT;
  localparam int DEN_W   = SPAN_W + DOWN_SHIFT;
  localparam int QUO_W   = CC_W + UP_SHIFT;
  localparam int R_W     = PHASE_BITS - 2;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int W_W     = 17;
  localparam int ACC_W   = 41;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_SPAN   = 3'd0,
    REG_CENTER = 3'd1,
    REG_SWING  = 3'd2,
    REG_CYCLES = 3'd3,
    REG_PHASE  = 3'd4,
    REG_SHAPE  = 3'd5,
    REG_MIN    = 3'd6,
    REG_MAX    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_SQUARE = 2'd2,
    SHAPE_SPARE  = 2'd3
  } shape_t;

  typedef logic [W_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  function automatic longint unsigned next_term(input longint unsigned term,
                                                input longint unsigned a);
    return (((term * a) >> 30) * a) >> 30;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t        t;
    longint unsigned  a;
    longint unsigned  term;
    longint unsigned  v;
    longint           sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      a    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
      term = a;
      sum  = longint'(a);
      term = next_term(term, a) / 64'd6;
      sum  = sum - longint'(term);
      term = next_term(term, a) / 64'd20;
      sum  = sum + longint'(term);
      term = next_term(term, a) / 64'd42;
      sum  = sum - longint'(term);
      term = next_term(term, a) / 64'd72;
      sum  = sum + longint'(term);
      term = next_term(term, a) / 64'd110;
      sum  = sum - longint'(term);
      term = next_term(term, a) / 64'd156;
      sum  = sum + longint'(term);
      term = next_term(term, a) / 64'd210;
      sum  = sum - longint'(term);
      term = next_term(term, a) / 64'd272;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) v = 64'd32768;
      t[i] = v[W_W-1:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

>>> sv/lfo_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lfo_pkg for the operand widths.
module lfo_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lfo_pkg::NUM_W-1:0]  num,
  input  logic [lfo_pkg::DEN_W-1:0]  den,
  output logic                       out_valid,
  output logic [lfo_pkg::QUO_W-1:0]  quot
);

  localparam int QW = lfo_pkg::QUO_W;
  localparam int DW = lfo_pkg::DEN_W;

  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic          vld [0:QW];

  assign rem[0] = DW'(num >> QW);
  assign low[0] = num[QW-1:0];
  assign vld[0] = in_valid;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      t    = {rem[s], low[s][QW-1]};
      diff = t - {1'b0, den};
      ge   = (t >= {1'b0, den});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low[s+1] <= {low[s][QW-2:0], ge};
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = low[QW];

endmodule

>>> sv/lfo_wave.sv
// Two-stage wave unit: quadrant/index decode, then signed sine or tri/square.
// Depends on lfo_pkg for the sine table and shape codes.
module lfo_wave (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [lfo_pkg::PHASE_BITS-1:0]   phase,
  input  lfo_pkg::shape_t                  shape,
  output logic                             out_valid,
  output logic signed [lfo_pkg::W_W-1:0]   wave
);

  localparam int PB = lfo_pkg::PHASE_BITS;
  localparam logic [PB-1:0] HALF = PB'(1) << (PB - 1);

  logic                          v1;
  logic                          use_tab1;
  logic                          neg1;
  logic [lfo_pkg::IDX_W-1:0]     j1;
  logic signed [lfo_pkg::W_W-1:0] alt1;

  logic [lfo_pkg::R_W-1:0]                   r;
  logic [lfo_pkg::R_W+lfo_pkg::IDX_W-1:0]    rprod;
  logic [lfo_pkg::IDX_W-1:0]                 idx;
  logic [PB-1:0]                             d;
  logic [PB+17-1:0]                          dsh;
  logic signed [18:0]                        tri_w;
  logic signed [lfo_pkg::W_W-1:0]            alt;

  always_comb begin
    r     = phase[lfo_pkg::R_W-1:0];
    rprod = (lfo_pkg::R_W + lfo_pkg::IDX_W)'(r) *
            (lfo_pkg::R_W + lfo_pkg::IDX_W)'(lfo_pkg::SINE_TABLE_DEPTH);
    idx   = lfo_pkg::IDX_W'(rprod >> lfo_pkg::R_W);
    d     = (phase >= HALF) ? phase - HALF : HALF - phase;
    dsh   = {d, 17'b0} >> PB;
    tri_w = 19'sd32768 - $signed({1'b0, dsh[17:0]});
    if (shape == lfo_pkg::SHAPE_TRI) begin
      alt = tri_w[lfo_pkg::W_W-1:0];
    end else begin
      alt = (phase < HALF) ? 17'sd32768 : -17'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      use_tab1 <= (shape != lfo_pkg::SHAPE_TRI) && (shape != lfo_pkg::SHAPE_SQUARE);
      neg1     <= phase[PB-1];
      j1       <= phase[PB-2] ? lfo_pkg::IDX_W'(lfo_pkg::SINE_TABLE_DEPTH) - idx : idx;
      alt1     <= alt;
      if (use_tab1) begin
        wave <= neg1 ? -$signed(lfo_pkg::SINE_TAB[j1]) : $signed(lfo_pkg::SINE_TAB[j1]);
      end else begin
        wave <= alt1;
      end
    end
  end

endmodule

>>> sv/lfo_level_generator.sv
// Top level of the LFO level generator: configuration registers, input and level stages.
// Depends on lfo_pkg, lfo_divider and lfo_wave.
//
// One level item is produced for each tick item, and a new tick item can be taken in every
// cycle while the output is not held. There is a saturation stage and a multiply stage, 24
// stages of the pipelined divider (one quotient bit each), two stages of the wave unit, an
// accumulate stage and the output register; a held output item holds the whole pipeline.
// Configuration must only be written while no item is in flight.
module lfo_level_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lfo_pkg::SPAN_W-1:0] tick_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lfo_pkg::OUT_W-1:0]  level,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [lfo_pkg::CFG_W-1:0]  cfg_data
);

  logic [lfo_pkg::SPAN_W-1:0]         span_ticks;
  logic signed [lfo_pkg::LEVEL_W-1:0] center_level;
  logic signed [lfo_pkg::LEVEL_W-1:0] swing;
  logic [lfo_pkg::CC_W-1:0]           cycle_count;
  logic [lfo_pkg::PO_W-1:0]           phase_offset;
  lfo_pkg::shape_t                    wave_shape;
  logic [lfo_pkg::OUT_W-1:0]          level_min;
  logic [lfo_pkg::OUT_W-1:0]          level_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_ticks   <= 32'd1;
      center_level <= 24'sd16256;
      swing        <= '0;
      cycle_count  <= 24'd65536;
      phase_offset <= '0;
      wave_shape   <= lfo_pkg::SHAPE_SINE;
      level_min    <= '0;
      level_max    <= 14'd127;
    end else if (cfg_we) begin
      case (lfo_pkg::cfg_reg_t'(cfg_index))
        lfo_pkg::REG_SPAN:   span_ticks   <= cfg_data;
        lfo_pkg::REG_CENTER: center_level <= cfg_data[lfo_pkg::LEVEL_W-1:0];
        lfo_pkg::REG_SWING:  swing        <= cfg_data[lfo_pkg::LEVEL_W-1:0];
        lfo_pkg::REG_CYCLES: cycle_count  <= cfg_data[lfo_pkg::CC_W-1:0];
        lfo_pkg::REG_PHASE:  phase_offset <= cfg_data[lfo_pkg::PO_W-1:0];
        lfo_pkg::REG_SHAPE:  wave_shape   <= lfo_pkg::shape_t'(cfg_data[1:0]);
        lfo_pkg::REG_MIN:    level_min    <= cfg_data[lfo_pkg::OUT_W-1:0];
        lfo_pkg::REG_MAX:    level_max    <= cfg_data[lfo_pkg::OUT_W-1:0];
        default: ;
      endcase
    end
  end

  logic                           en;
  logic [lfo_pkg::SPAN_W-1:0]     span_eff;
  logic                           v1;
  logic                           v2;
  logic [lfo_pkg::SPAN_W-1:0]     off1;
  logic [lfo_pkg::NUM_W-1:0]      num2;
  logic                           dv;
  logic [lfo_pkg::QUO_W-1:0]      quot;
  logic [lfo_pkg::PHASE_BITS-1:0] phase;
  logic [lfo_pkg::PHASE_BITS+lfo_pkg::PO_W-1:0] ph_base;
  logic                           wv;
  logic signed [lfo_pkg::W_W-1:0] wave;
  logic                           va;
  logic signed [lfo_pkg::ACC_W-1:0] acc;
  logic [lfo_pkg::ACC_W-1:0]      mag_full;
  logic [17:0]                    mag;
  logic signed [18:0]             lvl;
  logic signed [18:0]             lvl_lo;
  logic signed [18:0]             lvl_cl;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign span_eff = (span_ticks == '0) ? lfo_pkg::SPAN_W'(1) : span_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      va <= wv;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off1 <= (tick_offset > span_eff) ? span_eff : tick_offset;
      num2 <= lfo_pkg::NUM_W'((lfo_pkg::NUM_W'(cycle_count) * lfo_pkg::NUM_W'(off1))
              << lfo_pkg::UP_SHIFT);
    end
  end

  lfo_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .num       (num2),
    .den       (lfo_pkg::DEN_W'(lfo_pkg::DEN_W'(span_eff) << lfo_pkg::DOWN_SHIFT)),
    .out_valid (dv),
    .quot      (quot)
  );

  always_comb begin
    ph_base = ((lfo_pkg::PHASE_BITS + lfo_pkg::PO_W)'(phase_offset) << lfo_pkg::UP_SHIFT)
              >> lfo_pkg::DOWN_SHIFT;
    phase   = ph_base[lfo_pkg::PHASE_BITS-1:0] + quot[lfo_pkg::PHASE_BITS-1:0];
  end

  lfo_wave u_wave (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv),
    .phase     (phase),
    .shape     (wave_shape),
    .out_valid (wv),
    .wave      (wave)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= (lfo_pkg::ACC_W'(center_level) <<< 15) +
             lfo_pkg::ACC_W'(swing * wave);
      level <= lvl_cl[lfo_pkg::OUT_W-1:0];
    end
  end

  always_comb begin
    mag_full = acc[lfo_pkg::ACC_W-1] ? lfo_pkg::ACC_W'(-acc) : lfo_pkg::ACC_W'(acc);
    mag_full = (mag_full + (lfo_pkg::ACC_W'(1) << 22)) >> 23;
    mag      = mag_full[17:0];
    lvl      = acc[lfo_pkg::ACC_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    lvl_lo   = (lvl < $signed({5'b0, level_min})) ? $signed({5'b0, level_min}) : lvl;
    lvl_cl   = (lvl_lo > $signed({5'b0, level_max})) ? $signed({5'b0, level_max}) : lvl_lo;
  end

endmodule

>>> sv/lfo_checker.sv
// Port-level checker for the LFO level generator, bound to the top level.
// Depends only on the top level's ports.
module lfo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] level
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output item present after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no output item waiting");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> in_ready)
    else $error("input stalled while the output item is taken");

  a_level_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(level)))
    else $error("stalled output item changed");

endmodule

bind lfo_level_generator lfo_checker u_lfo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level     (level)
);
